// File: hdl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
// Holds item structs, mode/status/register codes, the sequencer state type
// and the count-to-order helper. No dependencies.
package bpa_pkg;

	// field widths
	localparam int FW  = 20;   // page frame
	localparam int CW  = 11;   // page counts
	localparam int XW  = 22;   // extended index arithmetic
	localparam int BMW = 32;   // bitmap row width
	localparam int LBW = 5;    // log2 of bitmap row width

	localparam int DEF_NUM_PAGES = 1024;
	localparam int DEF_MAX_ORDER = 10;

	localparam logic [FW-1:0] BASE_RESET = 20'd256;
	localparam logic [CW-1:0] PIU_RESET  = 11'd1024;

	// request modes
	localparam logic [1:0] MODE_ALLOC  = 2'd0;
	localparam logic [1:0] MODE_FREE   = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;
	localparam logic [1:0] MODE_REINIT = 2'd3;

	// result status
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_REQ  = 2'd1;
	localparam logic [1:0] STAT_NO_BLOCK = 2'd2;
	localparam logic [1:0] STAT_BAD_FREE = 2'd3;

	// configuration register indexes
	localparam logic CFG_BASE_PAGE    = 1'b0;
	localparam logic CFG_PAGES_IN_USE = 1'b1;

	typedef struct packed {
		logic [1:0]    mode;
		logic [CW-1:0] page_count;
		logic [FW-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic [1:0]    status;
		logic [FW-1:0] granted_page;
		logic [3:0]    granted_order;
		logic          page_is_allocated;
		logic [CW-1:0] free_count;
		logic [CW-1:0] used_count;
	} rsp_t;

	typedef enum logic [5:0] {
		S_INIT_CLR, S_INIT_BLD, S_IDLE, S_DISP,
		S_AL_FIND, S_AL_SPLIT, S_AL_MRD, S_AL_MWR, S_AL_FIN,
		S_FR_RD, S_FR_LOOP, S_FR_BCHK, S_FR_M1, S_FR_M2, S_FR_M3, S_FR_M4,
		S_FR_APP, S_FR_FIN, S_Q_BIT,
		S_U_RD, S_U_CHK, S_U_PRD, S_U_PWR, S_U_NX, S_U_NWR, S_U_WX,
		S_A_TL, S_A_TWR, S_A_WX,
		S_B_RD, S_B_WR, S_DONE
	} st_t;

	// smallest order whose block holds cnt pages, capped at maxo
	function automatic logic [4:0] order_for(input logic [CW-1:0] cnt,
			input logic [4:0] maxo);
		logic [4:0] r;
		r = 5'(CW);
		for (int o = CW; o >= 0; o--) begin
			if ((XW'(1) << o) >= XW'(cnt))
				r = 5'(o);
		end
		if (r > maxo)
			r = maxo;
		return r;
	endfunction

endpackage

// File: hdl/buddy_page_allocator.sv
// Buddy page allocator top level: sequencer, node table and bitmap memories.
// Depends on bpa_pkg.
//
// One item is worked at a time by a sequencer that reads, modifies and writes
// back a node-table memory (one entry per page, list links and order) and a
// bitmap memory of 32-page rows, both with registered read data; accesses
// are serialized so no two overlap. An allocate does the list unlink, an append
// per split buddy, the head update and a read-modify-write per bitmap row
// touched. A free does a node update, a read-modify-write per bitmap row, each
// merge step and the final append. An item's time is the sum of its steps, so
// the rate is set by the node-table port. After reset, and on a reinitialize
// item, a clearing pass over every entry zeroes both memories and is followed
// by an append for each initial free block; no item is taken meanwhile. A
// finished result sits in an output register, so the next item is accepted
// while it waits.
module buddy_page_allocator
	import bpa_pkg::*;
#(
	parameter int NUM_PAGES = DEF_NUM_PAGES,
	parameter int MAX_ORDER = DEF_MAX_ORDER
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  req_t          req_item,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rsp_t          rsp_item,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [FW-1:0] cfg_wdata
);

	localparam int PW  = $clog2(NUM_PAGES);
	localparam int OW  = $clog2(MAX_ORDER + 1);
	localparam int NL  = MAX_ORDER + 1;
	localparam int NR  = (NUM_PAGES + BMW - 1) / BMW;
	localparam int RAW = (NR > 1) ? $clog2(NR) : 1;
	localparam int MGD_RST = (NUM_PAGES < 1024) ? NUM_PAGES : 1024;

	typedef struct packed {
		logic [OW-1:0] order;
		logic          alloc;
		logic          on_list;
		logic          has_next;
		logic          has_prev;
		logic [PW-1:0] nxt;
		logic [PW-1:0] prv;
	} node_t;

	st_t state_q, state_d, ret_q;

	logic [1:0]    mode_q;
	logic [CW-1:0] cnt_q;
	logic [FW-1:0] idx_q;
	logic [OW-1:0] req_q;

	logic [FW-1:0] base_q;
	logic [CW-1:0] piu_q, mgd_q, free_q, used_q;

	logic [NL-1:0] ne_q;
	logic [PW-1:0] head_q [NL];
	logic [PW-1:0] tail_q [NL];

	logic [PW-1:0] blk_q, bud_q, x_q;
	logic [OW-1:0] o_q, xo_q;
	node_t         xn_q;
	logic          app_q, rinit_q;
	logic [XW-1:0] ii_q, bs_q, lim_q, rb_q;
	logic          bval_q;

	logic [1:0]    stat_q;
	logic [FW-1:0] gp_q;
	logic [3:0]    go_q;
	logic          qb_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// memories
	node_t         node_mem [NUM_PAGES];
	node_t         nrd_q, nwd;
	logic          nwe;
	logic [PW-1:0] nwa, nra;
	logic [BMW-1:0] bm_mem [NR];
	logic [BMW-1:0] bm_rd_q, bwd, bmask;
	logic          bwe;
	logic [RAW-1:0] bwa, bra;

	// combinational helpers
	logic [XW-1:0] mgd_x, sbud_x, fbud_x, blk_sz, mgd_new_x, lo_x, diff_x;
	logic [CW-1:0] mgd_new;
	logic          idx_in, f_found, leave_done, unl_ok;
	logic [OW-1:0] f_ord, ik, lsel;
	logic [PW-1:0] lhead, ltail;
	logic          lne;
	logic [LBW:0]  lo6, hi6;

	assign mgd_x   = XW'(mgd_q);
	assign idx_in  = XW'(idx_q) < mgd_x;
	assign sbud_x  = XW'(blk_q) ^ (XW'(1) << (o_q - OW'(1)));
	assign fbud_x  = XW'(blk_q) ^ (XW'(1) << o_q);
	assign blk_sz  = XW'(1) << req_q;
	assign mgd_new_x = (XW'(piu_q) < XW'(NUM_PAGES)) ? XW'(piu_q) : XW'(NUM_PAGES);
	assign mgd_new = CW'(mgd_new_x);
	assign unl_ok  = nrd_q.on_list && (nrd_q.order <= OW'(MAX_ORDER));
	assign leave_done = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	// list selector for the end-pointer registers
	always_comb begin
		case (state_q)
			S_AL_FIND: lsel = f_ord;
			S_U_CHK:   lsel = nrd_q.order;
			S_U_NX:    lsel = xn_q.order;
			default:   lsel = xo_q;
		endcase
	end
	assign lhead = head_q[lsel];
	assign ltail = tail_q[lsel];
	assign lne   = ne_q[lsel];

	// first non-empty list at or above the requested order
	always_comb begin
		f_found = 1'b0;
		f_ord   = '0;
		for (int o = MAX_ORDER; o >= 0; o--) begin
			if (ne_q[o] && (OW'(o) >= req_q)) begin
				f_found = 1'b1;
				f_ord   = OW'(o);
			end
		end
	end

	// largest aligned block that fits at the init cursor
	always_comb begin
		ik = '0;
		for (int k = 0; k <= MAX_ORDER; k++) begin
			if (((ii_q & ((XW'(1) << k) - XW'(1))) == '0) &&
					((ii_q + (XW'(1) << k)) <= mgd_x))
				ik = OW'(k);
		end
	end

	// bit mask of the current bitmap row inside the range
	always_comb begin
		lo_x   = (bs_q > rb_q) ? (bs_q - rb_q) : '0;
		diff_x = lim_q - rb_q;
		lo6    = (LBW+1)'(lo_x);
		hi6    = (diff_x >= XW'(BMW)) ? (LBW+1)'(BMW) : (LBW+1)'(diff_x);
		for (int j = 0; j < BMW; j++)
			bmask[j] = ((LBW+1)'(j) >= lo6) && ((LBW+1)'(j) < hi6);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT_CLR: if (ii_q == XW'(NUM_PAGES - 1)) state_d = S_INIT_BLD;
			S_INIT_BLD: begin
				if (ii_q < mgd_x)
					state_d = S_U_RD;
				else
					state_d = rinit_q ? S_DONE : S_IDLE;
			end
			S_IDLE: if (req_valid) state_d = S_DISP;
			S_DISP: begin
				case (mode_q)
					MODE_ALLOC: state_d = (cnt_q == '0) ? S_DONE : S_AL_FIND;
					MODE_FREE: begin
						if (cnt_q == '0 || !idx_in)
							state_d = S_DONE;
						else
							state_d = S_FR_RD;
					end
					MODE_QUERY:  state_d = idx_in ? S_Q_BIT : S_DONE;
					MODE_REINIT: state_d = S_INIT_CLR;
					default:     state_d = S_DONE;
				endcase
			end
			S_AL_FIND:  state_d = f_found ? S_U_RD : S_DONE;
			S_AL_SPLIT: begin
				if (o_q > req_q)
					state_d = (sbud_x < mgd_x) ? S_U_RD : S_AL_SPLIT;
				else
					state_d = S_AL_MRD;
			end
			S_AL_MRD: state_d = S_AL_MWR;
			S_AL_MWR: state_d = S_B_RD;
			S_AL_FIN: state_d = S_DONE;
			S_FR_RD:  state_d = nrd_q.alloc ? S_B_RD : S_DONE;
			S_FR_LOOP: begin
				if ((o_q < OW'(MAX_ORDER)) && (fbud_x < mgd_x))
					state_d = S_FR_BCHK;
				else
					state_d = S_FR_APP;
			end
			S_FR_BCHK: begin
				if (!nrd_q.on_list || nrd_q.alloc || (nrd_q.order != o_q))
					state_d = S_FR_APP;
				else
					state_d = S_U_RD;
			end
			S_FR_M1:  state_d = S_FR_M2;
			S_FR_M2:  state_d = S_FR_M3;
			S_FR_M3:  state_d = S_FR_M4;
			S_FR_M4:  state_d = S_FR_LOOP;
			S_FR_APP: state_d = S_U_RD;
			S_FR_FIN: state_d = S_DONE;
			S_Q_BIT:  state_d = S_DONE;
			S_U_RD:   state_d = S_U_CHK;
			S_U_CHK: begin
				if (unl_ok)
					state_d = nrd_q.has_prev ? S_U_PRD : S_U_NX;
				else
					state_d = app_q ? S_A_TL : S_U_WX;
			end
			S_U_PRD: state_d = S_U_PWR;
			S_U_PWR: state_d = S_U_NX;
			S_U_NX: begin
				if (xn_q.has_next)
					state_d = S_U_NWR;
				else
					state_d = app_q ? S_A_TL : S_U_WX;
			end
			S_U_NWR: state_d = app_q ? S_A_TL : S_U_WX;
			S_U_WX:  state_d = ret_q;
			S_A_TL:  state_d = lne ? S_A_TWR : S_A_WX;
			S_A_TWR: state_d = S_A_WX;
			S_A_WX:  state_d = ret_q;
			S_B_RD:  state_d = (rb_q < lim_q) ? S_B_WR : ret_q;
			S_B_WR:  state_d = S_B_RD;
			S_DONE:  if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		nwe = 1'b0;
		nwa = x_q;
		nra = x_q;
		nwd = nrd_q;
		bwe = 1'b0;
		bwa = RAW'(rb_q >> LBW);
		bra = RAW'(rb_q >> LBW);
		bwd = '0;
		case (state_q)
			S_INIT_CLR: begin
				nwe = 1'b1;
				nwa = PW'(ii_q);
				nwd = '0;
				bwe = ii_q < XW'(NR);
				bwa = RAW'(ii_q);
			end
			S_DISP: begin
				nra = PW'(idx_q);
				bra = RAW'(idx_q >> LBW);
			end
			S_AL_MRD: nra = blk_q;
			S_AL_MWR: begin
				nwe = 1'b1;
				nwa = blk_q;
				nwd.order = req_q;
				nwd.alloc = 1'b1;
			end
			S_FR_RD: begin
				nwe = nrd_q.alloc;
				nwa = PW'(idx_q);
				nwd.alloc = 1'b0;
				nwd.order = req_q;
			end
			S_FR_LOOP: nra = PW'(fbud_x);
			S_FR_M1:   nra = (bud_q < blk_q) ? blk_q : bud_q;
			S_FR_M2: begin
				nwe = 1'b1;
				nwa = (bud_q < blk_q) ? blk_q : bud_q;
				nwd.order = '0;
			end
			S_FR_M3: nra = blk_q;
			S_FR_M4: begin
				nwe = 1'b1;
				nwa = blk_q;
				nwd.order = o_q;
			end
			S_U_RD:  nra = x_q;
			S_U_PRD: nra = xn_q.prv;
			S_U_PWR: begin
				nwe = 1'b1;
				nwa = xn_q.prv;
				nwd.nxt = xn_q.nxt;
				nwd.has_next = xn_q.has_next;
			end
			S_U_NX: nra = xn_q.nxt;
			S_U_NWR: begin
				nwe = 1'b1;
				nwa = xn_q.nxt;
				nwd.prv = xn_q.prv;
				nwd.has_prev = xn_q.has_prev;
			end
			S_U_WX: begin
				nwe = 1'b1;
				nwa = x_q;
				nwd = xn_q;
				nwd.on_list  = 1'b0;
				nwd.has_next = 1'b0;
				nwd.has_prev = 1'b0;
			end
			S_A_TL: nra = ltail;
			S_A_TWR: begin
				nwe = 1'b1;
				nwa = ltail;
				nwd.nxt = x_q;
				nwd.has_next = 1'b1;
			end
			S_A_WX: begin
				nwe = 1'b1;
				nwa = x_q;
				nwd = xn_q;
				nwd.order    = xo_q;
				nwd.alloc    = 1'b0;
				nwd.on_list  = 1'b1;
				nwd.has_next = 1'b0;
				nwd.has_prev = lne;
				if (lne)
					nwd.prv = ltail;
			end
			S_B_WR: begin
				bwe = 1'b1;
				bwd = bval_q ? (bm_rd_q | bmask) : (bm_rd_q & ~bmask);
			end
			default: ;
		endcase
	end

	// node table memory
	always_ff @(posedge clk) begin
		if (nwe)
			node_mem[nwa] <= nwd;
		nrd_q <= node_mem[nra];
	end

	// page bitmap memory, 32 pages per row
	always_ff @(posedge clk) begin
		if (bwe)
			bm_mem[bwa] <= bwd;
		bm_rd_q <= bm_mem[bra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT_CLR;
			ret_q       <= S_IDLE;
			app_q       <= 1'b0;
			rinit_q     <= 1'b0;
			ii_q        <= '0;
			ne_q        <= '0;
			mgd_q       <= CW'(MGD_RST);
			free_q      <= CW'(MGD_RST);
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
			base_q      <= BASE_RESET;
			piu_q       <= PIU_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE_PAGE:    base_q <= cfg_wdata;
					CFG_PAGES_IN_USE: piu_q  <= cfg_wdata[CW-1:0];
					default: ;
				endcase
			end
			if (leave_done)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_INIT_CLR: ii_q <= (ii_q == XW'(NUM_PAGES - 1)) ? '0 : ii_q + XW'(1);
				S_INIT_BLD: begin
					if (ii_q < mgd_x) begin
						ii_q  <= ii_q + (XW'(1) << ik);
						ret_q <= S_INIT_BLD;
						app_q <= 1'b1;
					end
				end
				S_IDLE: if (req_valid) rinit_q <= 1'b0;
				S_DISP: begin
					if (mode_q == MODE_REINIT) begin
						ii_q    <= '0;
						ne_q    <= '0;
						mgd_q   <= mgd_new;
						free_q  <= mgd_new;
						used_q  <= '0;
						rinit_q <= 1'b1;
					end
				end
				S_AL_FIND: begin
					if (f_found) begin
						ret_q <= S_AL_SPLIT;
						app_q <= 1'b0;
					end
				end
				S_AL_SPLIT: begin
					if (o_q > req_q && sbud_x < mgd_x) begin
						ret_q <= S_AL_SPLIT;
						app_q <= 1'b1;
					end
				end
				S_AL_MWR: ret_q <= S_AL_FIN;
				S_AL_FIN: begin
					used_q <= ((XW'(used_q) + blk_sz) > mgd_x) ? mgd_q
						: CW'(XW'(used_q) + blk_sz);
					free_q <= (blk_sz > XW'(free_q)) ? '0 : CW'(XW'(free_q) - blk_sz);
				end
				S_FR_RD: if (nrd_q.alloc) ret_q <= S_FR_LOOP;
				S_FR_BCHK: begin
					ret_q <= S_FR_M1;
					app_q <= 1'b0;
				end
				S_FR_APP: begin
					ret_q <= S_FR_FIN;
					app_q <= 1'b1;
				end
				S_FR_FIN: begin
					free_q <= ((XW'(free_q) + blk_sz) > mgd_x) ? mgd_q
						: CW'(XW'(free_q) + blk_sz);
					used_q <= (blk_sz > XW'(used_q)) ? '0 : CW'(XW'(used_q) - blk_sz);
				end
				S_U_CHK: if (unl_ok && !nrd_q.has_prev) ne_q[lsel] <= nrd_q.has_next;
				S_A_WX:  ne_q[lsel] <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (leave_done) begin
			rsp_q.status            <= stat_q;
			rsp_q.granted_page      <= gp_q;
			rsp_q.granted_order     <= go_q;
			rsp_q.page_is_allocated <= qb_q;
			rsp_q.free_count        <= free_q;
			rsp_q.used_count        <= used_q;
		end
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					mode_q <= req_item.mode;
					cnt_q  <= req_item.page_count;
					idx_q  <= req_item.page_number - base_q;
					req_q  <= OW'(order_for(req_item.page_count, 5'(MAX_ORDER)));
					stat_q <= STAT_OK;
					gp_q   <= '0;
					go_q   <= '0;
					qb_q   <= 1'b0;
				end
			end
			S_DISP: begin
				if ((mode_q == MODE_ALLOC || mode_q == MODE_FREE) && cnt_q == '0)
					stat_q <= STAT_BAD_REQ;
				else if (mode_q == MODE_FREE && !idx_in)
					stat_q <= STAT_BAD_FREE;
			end
			S_AL_FIND: begin
				if (f_found) begin
					o_q   <= f_ord;
					blk_q <= lhead;
					x_q   <= lhead;
				end else begin
					stat_q <= STAT_NO_BLOCK;
				end
			end
			S_AL_SPLIT: begin
				if (o_q > req_q) begin
					o_q <= o_q - OW'(1);
					if (sbud_x < mgd_x) begin
						x_q  <= PW'(sbud_x);
						xo_q <= o_q - OW'(1);
					end
				end
			end
			S_AL_MWR: begin
				bs_q   <= XW'(blk_q);
				lim_q  <= ((XW'(blk_q) + blk_sz) < mgd_x) ? (XW'(blk_q) + blk_sz) : mgd_x;
				rb_q   <= XW'(blk_q) & ~XW'(BMW - 1);
				bval_q <= 1'b1;
			end
			S_AL_FIN: begin
				gp_q <= base_q + FW'(blk_q);
				go_q <= 4'(req_q);
			end
			S_FR_RD: begin
				if (nrd_q.alloc) begin
					blk_q  <= PW'(idx_q);
					o_q    <= req_q;
					bs_q   <= XW'(idx_q);
					lim_q  <= ((XW'(idx_q) + blk_sz) < mgd_x) ? (XW'(idx_q) + blk_sz) : mgd_x;
					rb_q   <= XW'(idx_q) & ~XW'(BMW - 1);
					bval_q <= 1'b0;
				end else begin
					stat_q <= STAT_BAD_FREE;
				end
			end
			S_FR_LOOP: bud_q <= PW'(fbud_x);
			S_FR_BCHK: x_q <= bud_q;
			S_FR_M2: begin
				if (bud_q < blk_q)
					blk_q <= bud_q;
				o_q <= o_q + OW'(1);
			end
			S_FR_APP: begin
				x_q  <= blk_q;
				xo_q <= o_q;
			end
			S_FR_FIN: go_q <= 4'(req_q);
			S_Q_BIT:  qb_q <= bm_rd_q[idx_q[LBW-1:0]];
			S_INIT_BLD: begin
				x_q  <= PW'(ii_q);
				xo_q <= ik;
			end
			S_U_CHK: begin
				xn_q <= nrd_q;
				if (unl_ok && !nrd_q.has_prev)
					head_q[lsel] <= nrd_q.nxt;
			end
			S_U_NX: if (!xn_q.has_next && xn_q.has_prev) tail_q[lsel] <= xn_q.prv;
			S_A_WX: begin
				if (!lne)
					head_q[lsel] <= x_q;
				tail_q[lsel] <= x_q;
			end
			S_B_WR: rb_q <= rb_q + XW'(BMW);
			default: ;
		endcase
	end

endmodule

// File: hdl/bpa_checker.sv
// Port-level checks for the buddy page allocator, bound to the top level.
// Depends on bpa_pkg and buddy_page_allocator.
module bpa_checker
	import bpa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req_item,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_item
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
		else $error("result changed while stalled");

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("accepted item back to back");

	// failed items carry no grant
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_item.status != STAT_OK) |->
		(rsp_item.granted_page == '0) && (rsp_item.granted_order == '0))
		else $error("grant on failed item");

	// a set query bit comes only from a clean query
	a_query_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.page_is_allocated |->
		(rsp_item.status == STAT_OK) && (rsp_item.granted_page == '0))
		else $error("query bit with other result");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

// File: verif/tb_buddy_page_allocator.sv
// Self-checking testbench for buddy_page_allocator: directed and random items
// are checked against a behavioral buddy allocator kept in the testbench.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
`timescale 1ns / 100ps

module tb_buddy_page_allocator;
	import bpa_pkg::*;

	localparam int NPG  = DEF_NUM_PAGES;
	localparam int MAXO = DEF_MAX_ORDER;
	localparam int QUIET_LIMIT = 40000;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	req_t          req_item;
	logic          rsp_valid;
	logic          rsp_ready;
	rsp_t          rsp_item;
	logic          cfg_we;
	logic          cfg_index;
	logic [FW-1:0] cfg_wdata;

	buddy_page_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// idling percentages, set per phase
	int   send_idle_pct;
	int   recv_stall_pct;
	int   err_count;
	int   quiet_cycles;
	rsp_t pending_rsp[$];

	// blocks believed allocated, used to build well-formed frees
	int live_blk[$];
	int live_ord[$];

	// allocator mirror
	logic [FW-1:0] mir_base;
	int            mir_piu;
	int            managed;
	bit            bitmap[NPG];
	int            nd_order[NPG];
	bit            nd_alloc[NPG];
	bit            nd_onlist[NPG];
	bit            nd_hasnext[NPG];
	bit            nd_hasprev[NPG];
	int            nd_next[NPG];
	int            nd_prev[NPG];
	bit            fl_nonempty[MAXO+1];
	int            fl_head[MAXO+1];
	int            fl_tail[MAXO+1];
	int            free_total;
	int            used_total;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void unlink_block(int idx);
		if (!nd_onlist[idx] || nd_order[idx] > MAXO)
			return;
		if (nd_hasprev[idx]) begin
			nd_next[nd_prev[idx]] = nd_next[idx];
			nd_hasnext[nd_prev[idx]] = nd_hasnext[idx];
		end else begin
			fl_head[nd_order[idx]] = nd_next[idx];
			fl_nonempty[nd_order[idx]] = nd_hasnext[idx];
		end
		if (nd_hasnext[idx]) begin
			nd_prev[nd_next[idx]] = nd_prev[idx];
			nd_hasprev[nd_next[idx]] = nd_hasprev[idx];
		end else if (nd_hasprev[idx]) begin
			fl_tail[nd_order[idx]] = nd_prev[idx];
		end
		nd_onlist[idx] = 0;
		nd_hasnext[idx] = 0;
		nd_hasprev[idx] = 0;
	endfunction

	function automatic void append_block(int idx, int ord);
		if (ord > MAXO)
			return;
		unlink_block(idx);
		nd_order[idx] = ord;
		nd_alloc[idx] = 0;
		nd_onlist[idx] = 1;
		nd_hasnext[idx] = 0;
		if (fl_nonempty[ord]) begin
			nd_next[fl_tail[ord]] = idx;
			nd_hasnext[fl_tail[ord]] = 1;
			nd_prev[idx] = fl_tail[ord];
			nd_hasprev[idx] = 1;
		end else begin
			fl_head[ord] = idx;
			fl_nonempty[ord] = 1;
			nd_hasprev[idx] = 0;
		end
		fl_tail[ord] = idx;
	endfunction

	// cover the pages with maximal aligned free blocks
	function automatic void rebuild_lists();
		int i, k;
		managed = (mir_piu < NPG) ? mir_piu : NPG;
		for (i = 0; i < NPG; i++) begin
			bitmap[i] = 0; nd_order[i] = 0; nd_alloc[i] = 0; nd_onlist[i] = 0;
			nd_hasnext[i] = 0; nd_hasprev[i] = 0; nd_next[i] = 0; nd_prev[i] = 0;
		end
		for (i = 0; i <= MAXO; i++) begin
			fl_nonempty[i] = 0; fl_head[i] = 0; fl_tail[i] = 0;
		end
		i = 0;
		while (i < managed) begin
			k = MAXO;
			while (k > 0 && (((i & ((1 << k) - 1)) != 0) || i + (1 << k) > managed))
				k--;
			append_block(i, k);
			i += 1 << k;
		end
		free_total = managed;
		used_total = 0;
	endfunction

	function automatic int block_order(int cnt);
		int o;
		o = 0;
		while ((1 << o) < cnt && o < MAXO)
			o++;
		return o;
	endfunction

	function automatic void mark_pages(int start, int cnt, bit v);
		for (int i = 0; i < cnt; i++)
			if (start + i < managed)
				bitmap[start + i] = v;
	endfunction

	function automatic int sat_add(int a, int b);
		return (a + b > managed) ? managed : a + b;
	endfunction

	function automatic int sat_sub(int a, int b);
		return (b > a) ? 0 : a - b;
	endfunction

	// apply one item to the mirror and return the result it should give
	function automatic rsp_t allocator_result(req_t r);
		rsp_t          res;
		int            cnt, idx, req_o, o, blk, bud;
		bit            found;
		logic [FW-1:0] rel;
		res = '0;
		cnt = r.page_count;
		rel = r.page_number - mir_base;
		idx = rel;
		case (r.mode)
			MODE_ALLOC: begin
				if (cnt == 0) begin
					res.status = STAT_BAD_REQ;
				end else begin
					req_o = block_order(cnt);
					o = req_o;
					found = 0;
					blk = 0;
					while (o <= MAXO && !found) begin
						if (fl_nonempty[o]) begin
							blk = fl_head[o];
							unlink_block(blk);
							found = 1;
						end else begin
							o++;
						end
					end
					if (!found) begin
						res.status = STAT_NO_BLOCK;
					end else begin
						while (o > req_o) begin
							bud = blk ^ (1 << (o - 1));
							if (bud < managed)
								append_block(bud, o - 1);
							o--;
						end
						nd_order[blk] = req_o;
						nd_alloc[blk] = 1;
						mark_pages(blk, 1 << req_o, 1);
						used_total = sat_add(used_total, 1 << req_o);
						free_total = sat_sub(free_total, 1 << req_o);
						res.granted_page = mir_base + FW'(blk);
						res.granted_order = 4'(req_o);
					end
				end
			end
			MODE_FREE: begin
				if (cnt == 0) begin
					res.status = STAT_BAD_REQ;
				end else if (idx >= managed || !nd_alloc[idx]) begin
					res.status = STAT_BAD_FREE;
				end else begin
					req_o = block_order(cnt);
					blk = idx;
					o = req_o;
					mark_pages(idx, 1 << req_o, 0);
					nd_alloc[idx] = 0;
					nd_order[idx] = req_o;
					// merge upward while the buddy is a listed free head of equal order
					while (o < MAXO) begin
						bud = blk ^ (1 << o);
						if (bud >= managed)
							break;
						if (!nd_onlist[bud] || nd_alloc[bud] || nd_order[bud] != o)
							break;
						unlink_block(bud);
						if (bud < blk) begin
							nd_order[blk] = 0;
							blk = bud;
						end else begin
							nd_order[bud] = 0;
						end
						o++;
						nd_order[blk] = o;
					end
					append_block(blk, o);
					used_total = sat_sub(used_total, 1 << req_o);
					free_total = sat_add(free_total, 1 << req_o);
					res.granted_order = 4'(req_o);
				end
			end
			MODE_QUERY: begin
				if (idx < managed && bitmap[idx])
					res.page_is_allocated = 1'b1;
			end
			default: rebuild_lists();
		endcase
		res.free_count = CW'(free_total);
		res.used_count = CW'(used_total);
		return res;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		err_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected result, queue depth", 0, 1);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_item.status != want.status)
					report_mismatch("status", rsp_item.status, want.status);
				if (rsp_item.granted_page != want.granted_page)
					report_mismatch("granted_page", rsp_item.granted_page, want.granted_page);
				if (rsp_item.granted_order != want.granted_order)
					report_mismatch("granted_order", rsp_item.granted_order,
						want.granted_order);
				if (rsp_item.page_is_allocated != want.page_is_allocated)
					report_mismatch("page_is_allocated", rsp_item.page_is_allocated,
						want.page_is_allocated);
				if (rsp_item.free_count != want.free_count)
					report_mismatch("free_count", rsp_item.free_count, want.free_count);
				if (rsp_item.used_count != want.used_count)
					report_mismatch("used_count", rsp_item.used_count, want.used_count);
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		rsp_ready <= ($urandom % 100) >= recv_stall_pct;
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// send one item; called and returns just after a falling edge
	task automatic send_item(req_t r);
		rsp_t want;
		int   k;
		while (($urandom % 100) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req_item = r;
		do @(posedge clk); while (!req_ready);
		want = allocator_result(r);
		pending_rsp.push_back(want);
		// keep the list of live blocks in step
		if (r.mode == MODE_ALLOC && want.status == STAT_OK) begin
			live_blk.push_back(int'(FW'(want.granted_page - mir_base)));
			live_ord.push_back(want.granted_order);
		end else if (r.mode == MODE_FREE && want.status == STAT_OK) begin
			for (k = 0; k < live_blk.size(); k++)
				if (live_blk[k] == int'(FW'(r.page_number - mir_base))) begin
					live_blk.delete(k);
					live_ord.delete(k);
					break;
				end
		end else if (r.mode == MODE_REINIT) begin
			live_blk.delete();
			live_ord.delete();
		end
		@(negedge clk);
	endtask

	task automatic send_fields(logic [1:0] m, int cnt, logic [FW-1:0] pg);
		req_t r;
		r.mode = m;
		r.page_count = CW'(cnt);
		r.page_number = pg;
		send_item(r);
	endtask

	// wait until the block is idle with nothing outstanding
	task automatic drain();
		req_valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		do @(negedge clk); while (!req_ready);
	endtask

	task automatic write_reg(logic idx, logic [FW-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_BASE_PAGE)
			mir_base = val;
		else
			mir_piu = val[CW-1:0];
	endtask

	// the pages-in-use setting takes hold with a reinitialize; the base page applies at once
	task automatic set_config(logic [FW-1:0] base, int pages);
		drain();
		write_reg(CFG_BASE_PAGE, base);
		write_reg(CFG_PAGES_IN_USE, FW'(pages));
		send_fields(MODE_REINIT, $urandom_range(0, 2047), FW'($urandom));
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_fields(MODE_ALLOC, 0, 20'h0);             // zero count
		send_fields(MODE_FREE, 0, mir_base);           // zero count free
		send_fields(MODE_ALLOC, 1, 20'hFFFFF);
		send_fields(MODE_ALLOC, 1024, 20'h0);          // no order-10 block left
		send_fields(MODE_ALLOC, 2047, 20'h0);          // order saturates
		send_fields(MODE_ALLOC, 3, 20'h0);
		send_fields(MODE_QUERY, 0, mir_base);
		send_fields(MODE_QUERY, 0, mir_base + 20'd5);
		send_fields(MODE_QUERY, 0, mir_base - 20'd1);  // out of range
		send_fields(MODE_QUERY, 0, 20'hFFFFF);
		send_fields(MODE_FREE, 1, mir_base + 20'd2047); // out of range
		send_fields(MODE_FREE, 1, mir_base + 20'd1);   // not an allocated block
		send_fields(MODE_FREE, 4, mir_base);           // count differs from order
		send_fields(MODE_FREE, 4, mir_base + 20'd4);
		send_fields(MODE_REINIT, 0, 20'h0);
		send_fields(MODE_ALLOC, 1024, 20'h0);
		send_fields(MODE_ALLOC, 1, 20'h0);             // full
		send_fields(MODE_QUERY, 0, mir_base + 20'd1023);
		send_fields(MODE_FREE, 1024, mir_base);
		send_fields(MODE_ALLOC, 1, 20'h0);
		send_fields(MODE_ALLOC, 1, 20'h0);
		send_fields(MODE_FREE, 1, mir_base + 20'd1);   // buddy still allocated
		send_fields(MODE_FREE, 1, mir_base);           // merges back up
		send_fields(MODE_FREE, 1, mir_base);           // double free
	endtask

	// mostly well-formed alloc/free traffic with some noise
	task automatic run_random(int n);
		int sel, k, cnt;
		for (int i = 0; i < n; i++) begin
			sel = $urandom % 100;
			if (sel < 40) begin
				cnt = ($urandom % 10 == 0) ? $urandom_range(0, 2047)
					: $urandom_range(1, 1 << $urandom_range(0, 6));
				send_fields(MODE_ALLOC, cnt, FW'($urandom));
			end else if (sel < 75 && live_blk.size() != 0) begin
				k = $urandom % live_blk.size();
				cnt = ($urandom % 8 == 0) ? $urandom_range(1, 2047)
					: ((live_ord[k] == 0) ? 1
					: $urandom_range((1 << (live_ord[k] - 1)) + 1, 1 << live_ord[k]));
				send_fields(MODE_FREE, cnt, mir_base + FW'(live_blk[k]));
			end else if (sel < 88) begin
				send_fields(MODE_QUERY, $urandom_range(0, 2047),
					mir_base + FW'($urandom_range(0, NPG + 16)));
			end else if (sel < 98) begin
				send_fields(MODE_FREE, $urandom_range(0, 2047), FW'($urandom));
			end else begin
				send_fields(MODE_REINIT, $urandom_range(0, 2047), FW'($urandom));
			end
		end
	endtask

	task automatic test_default_busy();
		send_idle_pct = 57;
		recv_stall_pct = 0;
		set_config(20'd256, 1024);
		run_random(250);
	endtask

	task automatic test_min_pages_stall();
		send_idle_pct = 0;
		recv_stall_pct = 57;
		set_config(20'h00000, 1);
		run_random(60);
		set_config(20'hFFFFF, 1023);
		run_random(100);
		// hold off until every result is back
		drain();
		run_random(100);
	endtask

	task automatic test_odd_sizes_both_idle();
		send_idle_pct = 15;
		recv_stall_pct = 15;
		set_config(FW'($urandom), 600);
		run_random(150);
		set_config(20'hFFF00, 2047);
		run_random(100);
	endtask

	task automatic test_small_pages_no_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(FW'($urandom), $urandom_range(2, 40));
		run_random(250);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE_PAGE;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		err_count = 0;
		quiet_cycles = 0;
		mir_base = BASE_RESET;
		mir_piu = PIU_RESET;
		rebuild_lists();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		do @(negedge clk); while (!req_ready);

		test_directed();
		test_default_busy();
		test_min_pages_stall();
		test_odd_sizes_both_idle();
		test_small_pages_no_idle();

		drain();
		repeat (50) @(negedge clk);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
